[design/priority_round_robin_scheduler_defines.svh]
// Assertion macros for the priority round-robin scheduler.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define PRRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("prrs check failed");
`define PRRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("prrs check failed");
`else
`define PRRS_ASSERT(lbl, clk, rst, prop)
`define PRRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/prrs_pkg.sv]
// Shared constants, codes and command/status types of the scheduler.
// No dependencies.
package prrs_pkg;
  localparam int NUM_TASKS = 8;
  localparam int TASK_W = 3;
  localparam int CNT_W = 4;
  localparam int PRIO_W = 8;
  localparam int TICK_W = 32;
  localparam int ACTION_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [ACTION_W-1:0] ACT_START = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ACTIVATE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TERMINATE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WAIT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TICK = 3'd4;

  localparam logic [1:0] TS_SUSPENDED = 2'd0;
  localparam logic [1:0] TS_WAITING = 2'd1;
  localparam logic [1:0] TS_READY = 2'd2;
  localparam logic [1:0] TS_RUNNING = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_PRIORITIES = 2'd1;

  typedef struct packed {
    logic capture;
    logic apply;
    logic sort_pass;
    logic sort_odd;
    logic queue_clear;
    logic scan_step;
    logic pick;
    logic tick_step;
    logic load_out;
    logic [TASK_W-1:0] idx;
  } prrs_cmd_t;

  typedef struct packed {
    logic rebuild;
    logic tick;
    logic scan_stop;
    logic tick_release;
    logic pick_en;
    logic [CNT_W-1:0] task_count;
  } prrs_status_t;
endpackage

[design/prrs_req_if.sv]
// Request channel of the scheduler: action, task index and tick count.
// Depends on prrs_pkg.
interface prrs_req_if;
  import prrs_pkg::*;
  logic valid;
  logic ready;
  logic [ACTION_W-1:0] action;
  logic [TASK_W-1:0] task_index;
  logic [TICK_W-1:0] wait_ticks;
  modport source (output valid, action, task_index, wait_ticks, input ready);
  modport sink (input valid, action, task_index, wait_ticks, output ready);
endinterface

[design/prrs_rsp_if.sv]
// Result channel of the scheduler: running task, switch flag, queue depth.
// Depends on prrs_pkg.
interface prrs_rsp_if;
  import prrs_pkg::*;
  logic valid;
  logic ready;
  logic [TASK_W-1:0] running_task;
  logic switched;
  logic [CNT_W-1:0] ready_count;
  modport source (output valid, running_task, switched, ready_count, input ready);
  modport sink (input valid, running_task, switched, ready_count, output ready);
endinterface

[design/prrs_cfg_if.sv]
// Configuration write channel of the scheduler: register index and data.
// Depends on prrs_pkg.
interface prrs_cfg_if;
  import prrs_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/prrs_datapath.sv]
// Task table, sort network, ready queue and result registers of the scheduler.
// Depends on prrs_pkg; driven by prrs_ctrl commands.
module prrs_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  prrs_pkg::prrs_cmd_t            cmd,
  output prrs_pkg::prrs_status_t         status,
  input  logic [prrs_pkg::ACTION_W-1:0]  action,
  input  logic [prrs_pkg::TASK_W-1:0]    task_index,
  input  logic [prrs_pkg::TICK_W-1:0]    wait_ticks,
  input  logic                           cfg_we,
  input  logic [prrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prrs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [prrs_pkg::TASK_W-1:0]    running_task,
  output logic                           switched,
  output logic [prrs_pkg::CNT_W-1:0]     ready_count
);
  import prrs_pkg::*;

  logic [CNT_W-1:0] task_count;
  logic [CFG_DATA_W-1:0] prio;
  logic [1:0] tstate [NUM_TASKS];
  logic wen [NUM_TASKS];
  logic [TICK_W-1:0] wcnt [NUM_TASKS];
  logic [TASK_W-1:0] sorted [NUM_TASKS];
  logic [TASK_W-1:0] fifo [NUM_TASKS];
  logic [TASK_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [TASK_W-1:0] current;
  logic kernel;
  logic [ACTION_W-1:0] act_q;
  logic [TASK_W-1:0] idx_q;
  logic [TICK_W-1:0] ticks_q;
  logic [TASK_W-1:0] before_q;

  logic [TASK_W-1:0] sorted_next [NUM_TASKS];
  logic addressed;
  logic [TASK_W-1:0] s_cur, s_nxt;
  logic s_last, s_cur_susp, s_nxt_susp, s_lt, s_eq, s_push;
  logic [TASK_W-1:0] t_k;
  logic t_act;
  logic p_empty, p_pop, p_requeue;
  logic [TASK_W-1:0] p_nxt, p_head1;
  logic [CNT_W-1:0] p_count1;
  logic [CNT_W-1:0] cfg_cnt;

  function automatic logic [PRIO_W-1:0] prio_of(input logic [CFG_DATA_W-1:0] p,
                                                 input logic [TASK_W-1:0] t);
    prio_of = p[t*PRIO_W +: PRIO_W];
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) sorted_next[i] = sorted[i];
    for (int j = 0; j < NUM_TASKS - 1; j++) begin
      if (((j % 2) == int'(cmd.sort_odd)) && (CNT_W'(j + 1) < task_count) &&
          (prio_of(prio, sorted[j]) > prio_of(prio, sorted[j+1]))) begin
        sorted_next[j] = sorted[j+1];
        sorted_next[j+1] = sorted[j];
      end
    end
  end

  always_comb begin
    addressed = {1'b0, idx_q} < task_count;
    s_cur = sorted[cmd.idx];
    s_nxt = sorted[cmd.idx + 1'b1];
    s_last = ({1'b0, cmd.idx} + 1'b1) >= task_count;
    s_cur_susp = tstate[s_cur] == TS_SUSPENDED;
    s_nxt_susp = tstate[s_nxt] == TS_SUSPENDED;
    s_lt = prio_of(prio, s_cur) < prio_of(prio, s_nxt);
    s_eq = prio_of(prio, s_cur) == prio_of(prio, s_nxt);
    s_push = !s_cur_susp && (s_last || s_nxt_susp || s_lt || s_eq);
    t_k = sorted[cmd.idx];
    t_act = (tstate[t_k] == TS_SUSPENDED) && wen[t_k];
    p_empty = count == '0;
    p_pop = !p_empty;
    p_nxt = p_pop ? fifo[head] : current;
    p_head1 = p_pop ? head + 1'b1 : head;
    p_count1 = p_pop ? count - 1'b1 : count;
    p_requeue = (prio_of(prio, p_nxt) == prio_of(prio, current)) &&
                (tstate[current] != TS_SUSPENDED);
    cfg_cnt = cfg_data[CNT_W-1:0];
    if (cfg_cnt == '0) cfg_cnt = CNT_W'(1);
    else if (cfg_cnt > CNT_W'(NUM_TASKS)) cfg_cnt = CNT_W'(NUM_TASKS);
  end

  always_comb begin
    status.rebuild = (act_q == ACT_START) ||
                     (addressed && (act_q == ACT_ACTIVATE || act_q == ACT_TERMINATE ||
                                    act_q == ACT_WAIT));
    status.tick = act_q == ACT_TICK;
    status.scan_stop = !s_cur_susp && (s_last || s_nxt_susp || s_lt);
    status.tick_release = t_act && (wcnt[t_k] == '0);
    status.pick_en = kernel && (current != '0);
    status.task_count = task_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= CNT_W'(1);
      prio <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        tstate[i] <= TS_SUSPENDED;
        wen[i] <= 1'b0;
        sorted[i] <= TASK_W'(i);
      end
      head <= '0;
      count <= '0;
      current <= '0;
      kernel <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TASK_COUNT) begin
          task_count <= cfg_cnt;
          for (int i = 0; i < NUM_TASKS; i++) sorted[i] <= TASK_W'(i);
        end else if (cfg_index == CFG_TASK_PRIORITIES) begin
          prio <= cfg_data;
        end
      end
      if (cmd.queue_clear) begin
        head <= '0;
        count <= '0;
      end
      if (cmd.apply) begin
        unique case (act_q)
          ACT_START: begin
            kernel <= 1'b1;
            current <= '0;
            tstate[0] <= TS_WAITING;
          end
          ACT_ACTIVATE: if (addressed) tstate[idx_q] <= TS_WAITING;
          ACT_TERMINATE: if (addressed) tstate[idx_q] <= TS_SUSPENDED;
          ACT_WAIT: if (addressed) begin
            wen[idx_q] <= 1'b1;
            wcnt[idx_q] <= ticks_q;
            tstate[idx_q] <= TS_SUSPENDED;
          end
          default: ;
        endcase
      end
      if (cmd.sort_pass) begin
        for (int i = 0; i < NUM_TASKS; i++) sorted[i] <= sorted_next[i];
      end
      if (cmd.scan_step && s_push) begin
        if (count < CNT_W'(NUM_TASKS)) begin
          fifo[count[TASK_W-1:0]] <= s_cur;
          count <= count + 1'b1;
        end
        tstate[s_cur] <= TS_READY;
      end
      if (cmd.tick_step) begin
        if (status.tick_release) begin
          wen[t_k] <= 1'b0;
          tstate[t_k] <= TS_WAITING;
        end else if (t_act) begin
          wcnt[t_k] <= wcnt[t_k] - 1'b1;
        end
      end
      if (cmd.pick) begin
        if (p_empty && tstate[current] == TS_SUSPENDED) begin
          tstate[current] <= TS_RUNNING;
          fifo[head] <= current;
          count <= count + 1'b1;
        end else begin
          head <= p_head1;
          count <= p_count1;
          if (p_requeue) begin
            if (p_count1 < CNT_W'(NUM_TASKS)) begin
              fifo[p_head1 + p_count1[TASK_W-1:0]] <= current;
              count <= p_count1 + 1'b1;
            end
            tstate[current] <= TS_READY;
          end
          current <= p_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      idx_q <= task_index;
      ticks_q <= wait_ticks;
      before_q <= current;
    end
    if (cmd.load_out) begin
      running_task <= current;
      switched <= current != before_q;
      ready_count <= count;
    end
  end
endmodule

[design/prrs_ctrl.sv]
// Sequencer of the scheduler: apply, sort passes, queue scan, pick and tick walk.
// Depends on prrs_pkg and the assertion macro header.
`include "priority_round_robin_scheduler_defines.svh"
module prrs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  prrs_pkg::prrs_status_t status,
  output prrs_pkg::prrs_cmd_t    cmd
);
  import prrs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_APPLY = 3'd1;
  localparam logic [2:0] ST_SORT = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_PICK = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state, state_next;
  logic [TASK_W-1:0] pass, pass_next;
  logic [TASK_W-1:0] scan_idx, scan_idx_next;
  logic [TASK_W-1:0] tick_idx, tick_idx_next;
  logic in_tick, in_tick_next;
  logic out_valid_next;
  logic scan_last, tick_last;

  assign in_ready = state == ST_IDLE;
  assign scan_last = ({1'b0, scan_idx} + 1'b1) >= status.task_count;
  assign tick_last = ({1'b0, tick_idx} + 1'b1) >= status.task_count;

  always_comb begin
    state_next = state;
    pass_next = pass;
    scan_idx_next = scan_idx;
    tick_idx_next = tick_idx;
    in_tick_next = in_tick;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    cmd.idx = (state == ST_TICK) ? tick_idx : scan_idx;
    cmd.sort_odd = pass[0];
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        pass_next = '0;
        in_tick_next = 1'b0;
        tick_idx_next = '0;
        if (status.rebuild) state_next = ST_SORT;
        else if (status.tick) state_next = ST_TICK;
        else state_next = ST_DONE;
      end
      ST_SORT: begin
        cmd.sort_pass = 1'b1;
        cmd.queue_clear = pass == '0;
        scan_idx_next = '0;
        pass_next = pass + 1'b1;
        if (pass == TASK_W'(NUM_TASKS - 1)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        scan_idx_next = scan_idx + 1'b1;
        if (status.scan_stop || scan_last) begin
          if (in_tick) begin
            tick_idx_next = tick_idx + 1'b1;
            state_next = tick_last ? ST_DONE : ST_TICK;
          end else begin
            state_next = status.pick_en ? ST_PICK : ST_DONE;
          end
        end
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        state_next = ST_DONE;
      end
      ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (status.tick_release) begin
          pass_next = '0;
          in_tick_next = 1'b1;
          state_next = ST_SORT;
        end else begin
          tick_idx_next = tick_idx + 1'b1;
          if (tick_last) state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass <= '0;
      scan_idx <= '0;
      tick_idx <= '0;
      in_tick <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass <= pass_next;
      scan_idx <= scan_idx_next;
      tick_idx <= tick_idx_next;
      in_tick <= in_tick_next;
      out_valid <= out_valid_next;
    end
  end

  `PRRS_ASSERT(a_accept_apply, clk, rst, (in_valid && in_ready) |=> state == ST_APPLY)
  `PRRS_ASSERT(a_scan_range, clk, rst, state == ST_SCAN |-> {1'b0, scan_idx} < status.task_count)
  `PRRS_ASSERT(a_tick_range, clk, rst, state == ST_TICK |-> {1'b0, tick_idx} < status.task_count)
  `PRRS_ASSERT(a_done_hold, clk, rst, (state == ST_DONE && out_valid && !out_ready) |=> state == ST_DONE)
  `PRRS_ASSERT_ALWAYS(a_reset_idle, clk, (!rst && $past(rst)) |-> (state == ST_IDLE && !out_valid))
endmodule

[design/priority_round_robin_scheduler.sv]
// Priority round-robin task scheduler over eight task slots, task 0 idle.
// Channels: req carries one event (start, activate, terminate, wait, tick);
// rsp returns one result per event (running task, switch flag, queue depth);
// cfg writes task_count (index 0) and the packed priorities (index 1).
// Each event runs through a sequencer: an apply step; a start or an addressed
// activate/terminate/wait then adds eight odd/even sort passes, a scan of up
// to task_count table slots and, if started and task 0 is not current, a pick.
// A tick walks task_count slots, one per cycle, and every released task adds
// a full re-sort and scan before the walk goes on.
// One event is worked on at a time; req is ready only while the sequencer is
// idle, and a finished result sits in an output register while the next event
// is taken. If rsp stalls, a second result waits in its last state.
// Reset (rst, synchronous) suspends all tasks, sets task_count to 1, clears
// priorities and the queue, and restores the identity order. Config writes are
// always taken and must only be issued while the block is idle.
// Depends on prrs_pkg, the channel interfaces, prrs_ctrl and prrs_datapath.
module priority_round_robin_scheduler (
  input logic       clk,
  input logic       rst,
  prrs_req_if.sink  req,
  prrs_rsp_if.source rsp,
  prrs_cfg_if.sink  cfg
);
  import prrs_pkg::*;

  prrs_cmd_t cmd;
  prrs_status_t status;

  assign cfg.ready = 1'b1;

  prrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  prrs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .action       (req.action),
    .task_index   (req.task_index),
    .wait_ticks   (req.wait_ticks),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .running_task (rsp.running_task),
    .switched     (rsp.switched),
    .ready_count  (rsp.ready_count)
  );
endmodule
